// File: rtl/srgb_eg_pkg.sv
`default_nettype none
package srgb_eg_pkg;

  localparam int LIN_FRAC_BITS  = 16;
  localparam int GAIN_FRAC_BITS = 16;

  localparam int CODE_W = 8;
  localparam int NCODES = 1 << CODE_W;
  localparam int LIN_W  = LIN_FRAC_BITS + 1;
  localparam int GAIN_W = 24;
  localparam int PROD_W = LIN_W + GAIN_W;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 2;

  // lookup, multiply, round/saturate, then one stage per code bit of the search
  localparam int NSTG = 3 + CODE_W;

  localparam logic [ADDR_W-1:0] GAIN_ADDR  = ADDR_W'(0);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  localparam longint unsigned ONE_LIN = 64'd1 << LIN_FRAC_BITS;
  localparam longint unsigned ROUND_C = 64'd1 << (GAIN_FRAC_BITS - 1);

  // wide enough for n^5 * b^12 at the largest fraction width
  localparam int WIDE_W = 448;

  typedef logic [LIN_W-1:0] lin_tab_t [NCODES];

  typedef struct packed {
    logic [CODE_W-1:0] chan0_in;
    logic [CODE_W-1:0] chan1_in;
    logic [CODE_W-1:0] chan2_in;
  } pix_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] chan0_out;
    logic [CODE_W-1:0] chan1_out;
    logic [CODE_W-1:0] chan2_out;
  } pix_out_t;

  // sign of n/2^e - (a/b)^2.4, as n^5 * b^12 against a^12 * 2^(5e)
  function automatic int pow_cmp(longint unsigned n, int e, longint unsigned a,
                                 longint unsigned b);
    logic [WIDE_W-1:0] l;
    logic [WIDE_W-1:0] r;
    l = WIDE_W'(1);
    r = WIDE_W'(1);
    for (int i = 0; i < 5; i++) l = l * WIDE_W'(n);
    for (int i = 0; i < 12; i++) l = l * WIDE_W'(b);
    for (int i = 0; i < 12; i++) r = r * WIDE_W'(a);
    r = r << (5 * e);
    if (l > r) return 1;
    if (l < r) return -1;
    return 0;
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned a;
    for (int i = 0; i < NCODES; i++) begin
      if (100000 * i <= 4045 * 255) begin
        t[i] = LIN_W'((ONE_LIN * 200 * longint'(i) + 64'd329460) / 64'd658920);
      end else begin
        a  = 1000 * longint'(i) + 14025;
        lo = 0;
        hi = ONE_LIN + 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (pow_cmp(2 * mid - 1, LIN_FRAC_BITS + 1, a, 64'd269025) <= 0) lo = mid;
          else hi = mid;
        end
        t[i] = LIN_W'(lo);
      end
    end
    return t;
  endfunction

  function automatic lin_tab_t build_mid();
    lin_tab_t t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned a;
    longint unsigned c;
    t[0] = '0;
    for (int k = 1; k < NCODES; k++) begin
      c = 2 * longint'(k) - 1;
      if (100000 * c <= 4045 * 510) begin
        t[k] = LIN_W'((100 * c * ONE_LIN + 64'd658919) / 64'd658920);
      end else begin
        a  = 1000 * c + 28050;
        lo = 0;
        hi = ONE_LIN;
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          if (pow_cmp(mid, LIN_FRAC_BITS, a, 64'd538050) >= 0) hi = mid;
          else lo = mid;
        end
        t[k] = LIN_W'(hi);
      end
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam lin_tab_t MID_TAB = build_mid();

endpackage
`default_nettype wire

// File: rtl/srgb_eg_chan.sv
`default_nettype none
module srgb_eg_chan (
  input  wire logic                                  clk,
  input  wire logic [srgb_eg_pkg::NSTG-1:0]          stg_en,
  input  wire logic [srgb_eg_pkg::GAIN_W-1:0]        gain,
  input  wire logic [srgb_eg_pkg::CODE_W-1:0]        code_in,
  output logic      [srgb_eg_pkg::CODE_W-1:0]        code_out
);

  logic [srgb_eg_pkg::LIN_W-1:0]  lin_r;
  logic [srgb_eg_pkg::PROD_W-1:0] prod_r;
  logic [srgb_eg_pkg::PROD_W:0]   rnd_sum;
  logic [srgb_eg_pkg::PROD_W:0]   shifted;
  logic [srgb_eg_pkg::LIN_W-1:0]  scaled_nxt;
  logic [srgb_eg_pkg::LIN_W-1:0]  scaled_r;

  logic [srgb_eg_pkg::LIN_W-1:0]  sc_r [srgb_eg_pkg::CODE_W-1];
  logic [srgb_eg_pkg::CODE_W-1:0] cd_r [srgb_eg_pkg::CODE_W];

  always_ff @(posedge clk) begin
    if (stg_en[0]) lin_r  <= srgb_eg_pkg::LIN_TAB[code_in];
    if (stg_en[1]) prod_r <= srgb_eg_pkg::PROD_W'(lin_r) * srgb_eg_pkg::PROD_W'(gain);
    if (stg_en[2]) scaled_r <= scaled_nxt;
  end

  // round half up, drop the gain fraction, saturate at 1.0
  always_comb begin
    rnd_sum = (srgb_eg_pkg::PROD_W+1)'(prod_r) + (srgb_eg_pkg::PROD_W+1)'(srgb_eg_pkg::ROUND_C);
    shifted = rnd_sum >> srgb_eg_pkg::GAIN_FRAC_BITS;
    if (shifted > (srgb_eg_pkg::PROD_W+1)'(srgb_eg_pkg::ONE_LIN)) begin
      scaled_nxt = srgb_eg_pkg::LIN_W'(srgb_eg_pkg::ONE_LIN);
    end else begin
      scaled_nxt = shifted[srgb_eg_pkg::LIN_W-1:0];
    end
  end

  // binary search over the ascending thresholds, MSB first
  for (genvar j = 0; j < srgb_eg_pkg::CODE_W; j++) begin : g_srch
    logic [srgb_eg_pkg::LIN_W-1:0]  sc_prev;
    logic [srgb_eg_pkg::CODE_W-1:0] cd_prev;
    logic [srgb_eg_pkg::CODE_W-1:0] trial;
    logic [srgb_eg_pkg::CODE_W-1:0] cd_nxt;

    if (j == 0) begin : g_first
      assign sc_prev = scaled_r;
      assign cd_prev = '0;
    end else begin : g_rest
      assign sc_prev = sc_r[j-1];
      assign cd_prev = cd_r[j-1];
    end

    assign trial  = cd_prev | (srgb_eg_pkg::CODE_W'(1) << (srgb_eg_pkg::CODE_W - 1 - j));
    assign cd_nxt = (sc_prev >= srgb_eg_pkg::MID_TAB[trial]) ? trial : cd_prev;

    always_ff @(posedge clk) begin
      if (stg_en[3+j]) cd_r[j] <= cd_nxt;
    end

    if (j < srgb_eg_pkg::CODE_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (stg_en[3+j]) sc_r[j] <= sc_prev;
      end
    end
  end

  assign code_out = cd_r[srgb_eg_pkg::CODE_W-1];

endmodule
`default_nettype wire

// File: rtl/srgb_linear_exposure_gain_top.sv
`default_nettype none
// Channel  Ports                                         Moves
// -------  --------------------------------------------  ------------------------------
// input    in_valid, in_ready, in_pixel                  three sRGB bytes per transfer
// result   out_valid, out_ready, out_pixel               three sRGB bytes per transfer
// config   psel, penable, pwrite, paddr, pwdata,         exposure_gain at address 0
//          prdata, pready
//
// One pixel per clock while out_ready is high; the stages are table lookup, gain multiply,
// round/saturate, then eight binary-search steps over the threshold table.
// Synchronous active-low reset empties the pipeline and sets the gain to 1.0.
// Each stage holds while the stage after it is full and stalled, so bubbles
// close up under out_ready low and in_ready drops only when every stage is full.
module srgb_linear_exposure_gain_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire srgb_eg_pkg::pix_in_t              in_pixel,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output srgb_eg_pkg::pix_out_t                  out_pixel,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [srgb_eg_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [srgb_eg_pkg::DATA_W-1:0]    pwdata,
  output logic      [srgb_eg_pkg::DATA_W-1:0]    prdata,
  output logic                                   pready
);

  logic [srgb_eg_pkg::GAIN_W-1:0] gain_r;
  logic [srgb_eg_pkg::NSTG-1:0]   vld_r;
  logic [srgb_eg_pkg::NSTG-1:0]   vld_nxt;
  logic [srgb_eg_pkg::NSTG-1:0]   stg_en;
  logic [srgb_eg_pkg::CODE_W-1:0] chan0_code;
  logic [srgb_eg_pkg::CODE_W-1:0] chan1_code;
  logic [srgb_eg_pkg::CODE_W-1:0] chan2_code;

  assign pready = 1'b1;
  assign prdata = srgb_eg_pkg::DATA_W'(gain_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= srgb_eg_pkg::GAIN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == srgb_eg_pkg::GAIN_ADDR) begin
      gain_r <= pwdata[srgb_eg_pkg::GAIN_W-1:0];
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    stg_en[srgb_eg_pkg::NSTG-1] = !vld_r[srgb_eg_pkg::NSTG-1] || out_ready;
    for (int s = srgb_eg_pkg::NSTG - 2; s >= 0; s--) begin
      stg_en[s] = !vld_r[s] || stg_en[s+1];
    end
    vld_nxt[0] = stg_en[0] ? in_valid : vld_r[0];
    for (int s = 1; s < srgb_eg_pkg::NSTG; s++) begin
      vld_nxt[s] = stg_en[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = vld_r[srgb_eg_pkg::NSTG-1];
  assign out_pixel = {chan0_code, chan1_code, chan2_code};

  srgb_eg_chan u_chan0 (
    .clk      (clk),
    .stg_en   (stg_en),
    .gain     (gain_r),
    .code_in  (in_pixel.chan0_in),
    .code_out (chan0_code)
  );

  srgb_eg_chan u_chan1 (
    .clk      (clk),
    .stg_en   (stg_en),
    .gain     (gain_r),
    .code_in  (in_pixel.chan1_in),
    .code_out (chan1_code)
  );

  srgb_eg_chan u_chan2 (
    .clk      (clk),
    .stg_en   (stg_en),
    .gain     (gain_r),
    .code_in  (in_pixel.chan2_in),
    .code_out (chan2_code)
  );

endmodule
`default_nettype wire
